// ===== src/hhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP header stream parser package
// Shared types and constants for the parser and its checker.
// ----------------------------------------------------------------------------
`default_nettype none
package hhsp_pkg;

   typedef enum logic [3:0] {
      ST_REQ_METHOD  = 4'd0,
      ST_REQ_TARGET  = 4'd1,
      ST_REQ_VERSION = 4'd2,
      ST_REQ_KEY     = 4'd3,
      ST_REQ_VALUE   = 4'd4,
      ST_RSP_VERSION = 4'd5,
      ST_RSP_STATUS  = 4'd6,
      ST_RSP_REASON  = 4'd7,
      ST_RSP_KEY     = 4'd8,
      ST_RSP_VALUE   = 4'd9,
      ST_RSP_BODY    = 4'd10
   } parser_state_type;

   typedef enum logic [2:0] {
      LV_NONE   = 3'd0,
      LV_LEAD   = 3'd1,
      LV_DIGITS = 3'd2,
      LV_TRAIL  = 3'd3,
      LV_DONE   = 3'd4,
      LV_BAD    = 3'd5
   } length_status_type;

   localparam logic [3:0] KIND_NONE    = 4'd0;
   localparam logic [3:0] KIND_METHOD  = 4'd1;
   localparam logic [3:0] KIND_TARGET  = 4'd2;
   localparam logic [3:0] KIND_VERSION = 4'd3;
   localparam logic [3:0] KIND_STATUS  = 4'd4;
   localparam logic [3:0] KIND_REASON  = 4'd5;
   localparam logic [3:0] KIND_KEY     = 4'd6;
   localparam logic [3:0] KIND_VALUE   = 4'd7;
   localparam logic [3:0] KIND_BODY    = 4'd8;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_REQ_DONE = 3'd1;
   localparam logic [2:0] EV_HDR_DONE = 3'd2;
   localparam logic [2:0] EV_BODY_DONE = 3'd3;
   localparam logic [2:0] EV_ERROR    = 3'd4;
   localparam logic [2:0] EV_BAD_LEN  = 3'd5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [3:0] NAME_LEN = 4'd14;

   function automatic logic [7:0] length_name(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:  ch = "C";
         4'd1:  ch = "o";
         4'd2:  ch = "n";
         4'd3:  ch = "t";
         4'd4:  ch = "e";
         4'd5:  ch = "n";
         4'd6:  ch = "t";
         4'd7:  ch = "-";
         4'd8:  ch = "L";
         4'd9:  ch = "e";
         4'd10: ch = "n";
         4'd11: ch = "g";
         4'd12: ch = "t";
         4'd13: ch = "h";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   typedef struct packed {
      logic [3:0] token_kind;
      logic       is_delimiter;
      logic       token_end;
      logic [2:0] event_res;
   } tag_type;

endpackage
`default_nettype wire

// ===== src/hhsp_req_if.sv =====
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one stream byte per item.
// ----------------------------------------------------------------------------
`default_nettype none
interface hhsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== src/hhsp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Tagged byte result channel
// Valid/ready channel carrying one tagged byte per item.
// ----------------------------------------------------------------------------
`default_nettype none
interface hhsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [3:0]  token_kind;
   logic        is_delimiter;
   logic        token_end;
   logic [2:0]  event_res;
   logic [31:0] content_length;
   modport source (output valid, output out_byte, output token_kind, output is_delimiter,
                   output token_end, output event_res, output content_length, input ready);
   modport sink (input valid, input out_byte, input token_kind, input is_delimiter,
                 input token_end, input event_res, input content_length, output ready);
endinterface
`default_nettype wire

// ===== src/hhsp_length.sv =====
// ----------------------------------------------------------------------------
// Content-Length digit accumulator
// Works out the next length status and accumulator for one value byte.
// ----------------------------------------------------------------------------
`default_nettype none
module hhsp_length
   import hhsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire length_status_type      status,
   input  wire logic [LENGTH_BITS-1:0] acc,
   input  wire logic [7:0]             ch,
   output length_status_type           status_out,
   output logic [LENGTH_BITS-1:0]      acc_out
);
   logic [LENGTH_BITS+3:0] prod;
   logic [3:0]             digit;

   // acc*10 + digit with four guard bits tells us whether the sum still fits.
   always_comb begin
      digit = ch[3:0];
      prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{LENGTH_BITS{1'b0}}, digit};
      status_out = status;
      acc_out = acc;
      if (status == LV_LEAD || status == LV_DIGITS || status == LV_TRAIL) begin
         if (ch == CH_SPACE || ch == CH_TAB) begin
            if (status == LV_DIGITS) status_out = LV_TRAIL;
         end else if (ch >= CH_ZERO && ch <= CH_NINE && status != LV_TRAIL) begin
            if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
               status_out = LV_BAD;
            end else begin
               acc_out = prod[LENGTH_BITS-1:0];
               status_out = LV_DIGITS;
            end
         end else begin
            status_out = LV_BAD;
         end
      end
   end
endmodule
`default_nettype wire

// ===== src/hhsp_parser.sv =====
// ----------------------------------------------------------------------------
// Header tagging state machine
// Holds the parser state and tags one byte per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none
module hhsp_parser
   import hhsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        mode,
   input  wire logic        restart_req,
   input  wire logic        step,
   input  wire logic [7:0]  ch,
   output tag_type          tag,
   output logic [31:0]      length_out
);
   parser_state_type       state_ff, state_in;
   logic                   cr_ff, cr_in;
   logic                   text_ff, text_in;
   logic [3:0]             match_ff, match_in;
   logic                   mism_ff, mism_in;
   logic                   found_ff, found_in;
   length_status_type      lv_ff, lv_in, lv_fed;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in, acc_fed;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;

   parser_state_type start_state;
   logic    is_crlf, is_value, f_word, f_line, f_value, forbid, rs;
   logic    [7:0] end_ch;
   logic    [3:0] kind;
   parser_state_type next_st;

   hhsp_length #(.LENGTH_BITS(LENGTH_BITS)) u_length (
      .status(lv_ff), .acc(acc_ff), .ch(ch), .status_out(lv_fed), .acc_out(acc_fed)
   );

   always_comb begin
      start_state = mode ? ST_RSP_VERSION : ST_REQ_METHOD;
      f_word  = ch == CH_NUL || ch == CH_TAB || ch == CH_LF || ch == CH_CR;
      f_line  = ch == CH_SPACE || ch == CH_NUL || ch == CH_TAB || ch == CH_LF;
      f_value = ch == CH_NUL || ch == CH_LF;
      end_ch = CH_SPACE;
      is_crlf = 1'b0; is_value = 1'b0; forbid = f_word;
      kind = KIND_NONE; next_st = start_state;
      unique case (state_ff)
         ST_REQ_METHOD:  begin kind = KIND_METHOD;  next_st = ST_REQ_TARGET; end
         ST_REQ_TARGET:  begin kind = KIND_TARGET;  next_st = ST_REQ_VERSION; end
         ST_REQ_VERSION: begin
            kind = KIND_VERSION; next_st = ST_REQ_KEY; is_crlf = 1'b1; forbid = f_line;
         end
         ST_REQ_KEY:     next_st = ST_REQ_VALUE;
         ST_REQ_VALUE:   begin
            kind = KIND_VALUE; next_st = ST_REQ_KEY; is_crlf = 1'b1; forbid = f_value;
            is_value = 1'b1;
         end
         ST_RSP_VERSION: begin kind = KIND_VERSION; next_st = ST_RSP_STATUS; end
         ST_RSP_STATUS:  begin kind = KIND_STATUS;  next_st = ST_RSP_REASON; end
         ST_RSP_REASON:  begin
            kind = KIND_REASON; next_st = ST_RSP_KEY; is_crlf = 1'b1; forbid = f_line;
         end
         ST_RSP_KEY:     next_st = ST_RSP_VALUE;
         ST_RSP_VALUE:   begin
            kind = KIND_VALUE; next_st = ST_RSP_KEY; is_crlf = 1'b1; forbid = f_value;
            is_value = 1'b1;
         end
         ST_RSP_BODY:    kind = KIND_BODY;
         default:        kind = KIND_NONE;
      endcase

      state_in = state_ff; cr_in = cr_ff; text_in = text_ff; match_in = match_ff;
      mism_in = mism_ff; found_in = found_ff; lv_in = lv_ff; acc_in = acc_ff;
      rem_in = rem_ff; rs = 1'b0;
      tag = '0; length_out = '0;

      if (state_ff == ST_REQ_KEY || state_ff == ST_RSP_KEY) begin
         if (cr_ff) begin
            if (ch != CH_LF || text_ff) begin
               rs = 1'b1; tag.event_res = EV_ERROR;
            end else begin
               tag.is_delimiter = 1'b1;
               rs = 1'b1;
               if (!mode) tag.event_res = EV_REQ_DONE;
               else if (found_ff && lv_ff == LV_BAD) tag.event_res = EV_BAD_LEN;
               else begin
                  tag.event_res = EV_HDR_DONE;
                  if (found_ff) begin
                     length_out = 32'(acc_ff);
                     if (acc_ff != '0) begin
                        rs = 1'b0;
                        state_in = ST_RSP_BODY; cr_in = 1'b0; text_in = 1'b0;
                        match_in = '0; mism_in = 1'b0; found_in = 1'b0;
                        lv_in = LV_NONE; acc_in = '0; rem_in = acc_ff;
                     end
                  end
               end
            end
         end else if (ch == CH_CR) begin
            cr_in = 1'b1;
            tag.token_kind = text_ff ? KIND_KEY : KIND_NONE;
            tag.is_delimiter = 1'b1;
         end else if (ch == CH_COLON) begin
            tag.token_kind = KIND_KEY; tag.is_delimiter = 1'b1; tag.token_end = 1'b1;
            if (match_ff == NAME_LEN && !mism_ff && !found_ff) begin
               found_in = 1'b1; lv_in = LV_LEAD; acc_in = '0;
            end
            match_in = '0; mism_in = 1'b0; text_in = 1'b0; state_in = next_st;
         end else if (f_line) begin
            rs = 1'b1; tag.event_res = EV_ERROR;
         end else begin
            tag.token_kind = KIND_KEY; text_in = 1'b1;
            if (!mism_ff && match_ff < NAME_LEN && length_name(match_ff) == ch)
               match_in = match_ff + 4'd1;
            else
               mism_in = 1'b1;
         end
      end else if (state_ff == ST_RSP_BODY) begin
         tag.token_kind = KIND_BODY;
         if (rem_ff <= LENGTH_BITS'(1)) begin
            tag.token_end = 1'b1; tag.event_res = EV_BODY_DONE; rs = 1'b1;
         end else begin
            rem_in = rem_ff - LENGTH_BITS'(1);
         end
      end else if (kind == KIND_NONE) begin
         rs = 1'b1;
      end else begin
         // Plain token: scan for its end marker.
         if ((is_crlf && cr_ff && ch != CH_LF) ||
             (!(is_crlf && cr_ff) && !(is_crlf && ch == CH_CR) &&
              !(!is_crlf && ch == end_ch) && forbid)) begin
            rs = 1'b1; tag.event_res = EV_ERROR;
         end else begin
            tag.token_kind = kind;
            if (is_crlf && !cr_ff && ch == CH_CR) begin
               tag.is_delimiter = 1'b1; cr_in = 1'b1;
            end else if ((is_crlf && cr_ff) || (!is_crlf && ch == end_ch)) begin
               tag.is_delimiter = 1'b1; tag.token_end = 1'b1;
               cr_in = 1'b0; text_in = 1'b0; state_in = next_st;
               if (is_value) begin
                  if (lv_ff == LV_LEAD) lv_in = LV_BAD;
                  else if (lv_ff == LV_DIGITS || lv_ff == LV_TRAIL) lv_in = LV_DONE;
               end
            end else begin
               text_in = 1'b1;
               if (is_value) begin lv_in = lv_fed; acc_in = acc_fed; end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart_req || (step && rs)) begin
         state_ff <= reset ? ST_REQ_METHOD : start_state;
         cr_ff <= 1'b0; text_ff <= 1'b0; match_ff <= '0; mism_ff <= 1'b0;
         found_ff <= 1'b0; lv_ff <= LV_NONE; acc_ff <= '0; rem_ff <= '0;
      end else if (step) begin
         state_ff <= state_in; cr_ff <= cr_in; text_ff <= text_in; match_ff <= match_in;
         mism_ff <= mism_in; found_ff <= found_in; lv_ff <= lv_in; acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/http_header_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// HTTP header stream parser core
// Tags each byte of an HTTP/1.1 stream and delimits response bodies.
// ----------------------------------------------------------------------------
// The block takes one stream byte per item on the req channel and returns
// exactly one tagged item per byte on the rsp channel: the byte itself, its
// token kind, delimiter and token-end flags, an event code and, with header
// done, the announced Content-Length.
// The tag is worked out from the parser state in the accepting cycle and
// held in the result register, so an item appears on rsp in the cycle after
// it is accepted. One item can be taken every cycle while the receiver does
// not stall; the parser state update is the loop that sets this rate.
// The result register is a single stage. While the receiver stalls with a
// result pending, a new item is taken only in the cycle the pending result
// leaves, so ready on req follows ready on rsp when the stage is full.
// Reset clears the result stage, selects request mode and puts the parser
// at the start of a request line. A write on the csr port sets parse mode
// and restarts the parser in the start state of the new mode.
// ----------------------------------------------------------------------------
`default_nettype none
module http_header_stream_parser_core
   import hhsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_write_enable,
   input  wire logic   csr_write_data,
   hhsp_req_if.sink    req,
   hhsp_rsp_if.source  rsp
);
   logic        mode_ff;
   logic        valid_ff;
   logic [7:0]  byte_ff;
   tag_type     tag_ff, tag;
   logic [31:0] len_ff, len;
   logic        take;

   // The stage may refill as soon as its item is taken.
   assign req.ready = !valid_ff || rsp.ready;
   assign take = req.valid && req.ready;

   hhsp_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
      .clock(clock), .reset(reset), .mode(csr_write_enable ? csr_write_data : mode_ff),
      .restart_req(csr_write_enable), .step(take), .ch(req.data_byte),
      .tag(tag), .length_out(len)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) mode_ff <= csr_write_data;
         if (take) valid_ff <= 1'b1;
         else if (rsp.ready) valid_ff <= 1'b0;
      end
      if (take) begin
         byte_ff <= req.data_byte;
         tag_ff <= tag;
         len_ff <= len;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.token_kind = tag_ff.token_kind;
   assign rsp.is_delimiter = tag_ff.is_delimiter;
   assign rsp.token_end = tag_ff.token_end;
   assign rsp.event_res = tag_ff.event_res;
   assign rsp.content_length = len_ff;
endmodule
`default_nettype wire

// ===== src/hhsp_checker.sv =====
// ----------------------------------------------------------------------------
// Parser port checker
// Watches the top level ports for consistent tagging over time.
// ----------------------------------------------------------------------------
`default_nettype none
module hhsp_checker
   import hhsp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  token_kind,
   input wire logic        is_delimiter,
   input wire logic [2:0]  event_res,
   input wire logic [31:0] content_length
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped while stalled");
   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid) else $error("accepted item not shown");
   a_error_bare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res == EV_ERROR |-> token_kind == KIND_NONE && !is_delimiter)
      else $error("error item carries a tag");
   a_len_only_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res != EV_HDR_DONE |-> content_length == 32'd0)
      else $error("length outside header done");
endmodule

bind http_header_stream_parser_core hhsp_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .token_kind(rsp.token_kind),
   .is_delimiter(rsp.is_delimiter), .event_res(rsp.event_res),
   .content_length(rsp.content_length)
);
`default_nettype wire

// ===== tb/sv/tb_http_header_stream_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header stream parser core testbench
// Streams request and response messages, some of them well formed and some
// broken or mixed with noise, through the parser. Each accepted byte is run
// through a local tagging model, and every tagged item that comes back is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_http_header_stream_parser_core;
   import hhsp_pkg::*;

   localparam int  CLOCK_HIGH  = 6;
   localparam int  CLOCK_LOW   = 6;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  PHASE_BYTES = 100;
   localparam logic [63:0] LENGTH_MAX = 64'h0000_0000_FFFF_FFFF;

   // Outcomes of scanning one byte against the rules of a token.
   localparam int SCAN_TEXT  = 0;
   localparam int SCAN_CR    = 1;
   localparam int SCAN_END   = 2;
   localparam int SCAN_ERROR = 3;

   // Sets of bytes that are forbidden inside a token.
   localparam int SET_WORD  = 0;
   localparam int SET_LINE  = 1;
   localparam int SET_VALUE = 2;

   typedef struct {
      logic [7:0]  out_byte;
      logic [3:0]  token_kind;
      logic        is_delimiter;
      logic        token_end;
      logic [2:0]  event_res;
      logic [31:0] content_length;
   } tagged_byte_type;

   // The scoreboard keeps its own copy of the parser state. note_byte tags an
   // accepted byte and queues the tag; check_tag compares a returned item.
   class tag_scoreboard;
      logic              mode;
      parser_state_type  state;
      logic              seen_cr;
      logic              line_has_text;
      logic [3:0]        match_idx;
      logic              mismatch;
      logic              length_found;
      length_status_type length_status;
      logic [63:0]       length_acc;
      logic [63:0]       body_left;
      tagged_byte_type   expected_tags[$];
      int                error_count;

      function new();
         mode = 1'b0;
         error_count = 0;
         restart();
      endfunction

      function void restart();
         state = mode ? ST_RSP_VERSION : ST_REQ_METHOD;
         seen_cr = 1'b0;
         line_has_text = 1'b0;
         match_idx = 4'd0;
         mismatch = 1'b0;
         length_found = 1'b0;
         length_status = LV_NONE;
         length_acc = 64'd0;
         body_left = 64'd0;
      endfunction

      function void set_mode(logic m);
         mode = m;
         restart();
      endfunction

      function int pending();
         return expected_tags.size();
      endfunction

      function logic forbidden(logic [7:0] c, int set_id);
         case (set_id)
            SET_WORD: begin
               return c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_CR;
            end
            SET_LINE: begin
               return c == CH_SPACE || c == CH_NUL || c == CH_TAB || c == CH_LF;
            end
            default: begin
               return c == CH_NUL || c == CH_LF;
            end
         endcase
      endfunction

      function int scan(logic [7:0] c, logic [7:0] end_char, logic crlf, int set_id);
         if (crlf) begin
            if (seen_cr) return (c == CH_LF) ? SCAN_END : SCAN_ERROR;
            if (c == CH_CR) return SCAN_CR;
         end else if (c == end_char) begin
            return SCAN_END;
         end
         return forbidden(c, set_id) ? SCAN_ERROR : SCAN_TEXT;
      endfunction

      // Digits of a Content-Length value, with blanks allowed around them.
      function void feed_length(logic [7:0] c);
         logic [63:0] digit;
         if (length_status != LV_LEAD && length_status != LV_DIGITS
             && length_status != LV_TRAIL) return;
         if (c == CH_SPACE || c == CH_TAB) begin
            if (length_status == LV_DIGITS) length_status = LV_TRAIL;
         end else if (c >= CH_ZERO && c <= CH_NINE && length_status != LV_TRAIL) begin
            digit = {56'd0, c - CH_ZERO};
            if (length_acc > (LENGTH_MAX - digit) / 64'd10) begin
               length_status = LV_BAD;
            end else begin
               length_acc = length_acc * 64'd10 + digit;
               length_status = LV_DIGITS;
            end
         end else begin
            length_status = LV_BAD;
         end
      endfunction

      function void simple_token(logic [7:0] c, logic [7:0] end_char, logic crlf,
                                 int set_id, logic [3:0] kind, parser_state_type next,
                                 logic is_value, ref tagged_byte_type t);
         int k;
         k = scan(c, end_char, crlf, set_id);
         if (k == SCAN_ERROR) begin
            restart();
            t.event_res = EV_ERROR;
            return;
         end
         t.token_kind = kind;
         if (k == SCAN_TEXT) begin
            line_has_text = 1'b1;
            if (is_value) feed_length(c);
            return;
         end
         t.is_delimiter = 1'b1;
         if (k == SCAN_CR) begin
            seen_cr = 1'b1;
            return;
         end
         t.token_end = 1'b1;
         seen_cr = 1'b0;
         line_has_text = 1'b0;
         if (is_value) begin
            if (length_status == LV_LEAD) length_status = LV_BAD;
            else if (length_status == LV_DIGITS || length_status == LV_TRAIL)
               length_status = LV_DONE;
         end
         state = next;
      endfunction

      function logic [7:0] key_char(logic [3:0] idx);
         string name;
         name = "Content-Length";
         return name[idx];
      endfunction

      function void key_byte(logic [7:0] c, parser_state_type value_state,
                             ref tagged_byte_type t);
         logic [63:0] len;
         if (seen_cr) begin
            // A nonblank line that reaches its LF without a colon is an error.
            if (c != CH_LF || line_has_text) begin
               restart();
               t.event_res = EV_ERROR;
               return;
            end
            t.is_delimiter = 1'b1;
            if (!mode) begin
               restart();
               t.event_res = EV_REQ_DONE;
               return;
            end
            if (length_found && length_status == LV_BAD) begin
               restart();
               t.event_res = EV_BAD_LEN;
               return;
            end
            len = length_found ? length_acc : 64'd0;
            t.event_res = EV_HDR_DONE;
            t.content_length = len[31:0];
            restart();
            if (len != 64'd0) begin
               body_left = len;
               state = ST_RSP_BODY;
            end
            return;
         end
         if (c == CH_CR) begin
            seen_cr = 1'b1;
            t.token_kind = line_has_text ? KIND_KEY : KIND_NONE;
            t.is_delimiter = 1'b1;
            return;
         end
         if (c == CH_COLON) begin
            t.token_kind = KIND_KEY;
            t.is_delimiter = 1'b1;
            t.token_end = 1'b1;
            if (match_idx == NAME_LEN && !mismatch && !length_found) begin
               length_found = 1'b1;
               length_status = LV_LEAD;
               length_acc = 64'd0;
            end
            match_idx = 4'd0;
            mismatch = 1'b0;
            line_has_text = 1'b0;
            state = value_state;
            return;
         end
         if (forbidden(c, SET_LINE)) begin
            restart();
            t.event_res = EV_ERROR;
            return;
         end
         t.token_kind = KIND_KEY;
         line_has_text = 1'b1;
         if (!mismatch && match_idx < NAME_LEN && key_char(match_idx) == c)
            match_idx = match_idx + 4'd1;
         else
            mismatch = 1'b1;
      endfunction

      function void note_byte(logic [7:0] c);
         tagged_byte_type t;
         t.out_byte = c;
         t.token_kind = KIND_NONE;
         t.is_delimiter = 1'b0;
         t.token_end = 1'b0;
         t.event_res = EV_NONE;
         t.content_length = 32'd0;
         case (state)
            ST_REQ_METHOD:  simple_token(c, CH_SPACE, 1'b0, SET_WORD, KIND_METHOD,
                                         ST_REQ_TARGET, 1'b0, t);
            ST_REQ_TARGET:  simple_token(c, CH_SPACE, 1'b0, SET_WORD, KIND_TARGET,
                                         ST_REQ_VERSION, 1'b0, t);
            ST_REQ_VERSION: simple_token(c, CH_NUL, 1'b1, SET_LINE, KIND_VERSION,
                                         ST_REQ_KEY, 1'b0, t);
            ST_REQ_KEY:     key_byte(c, ST_REQ_VALUE, t);
            ST_REQ_VALUE:   simple_token(c, CH_NUL, 1'b1, SET_VALUE, KIND_VALUE,
                                         ST_REQ_KEY, 1'b1, t);
            ST_RSP_VERSION: simple_token(c, CH_SPACE, 1'b0, SET_WORD, KIND_VERSION,
                                         ST_RSP_STATUS, 1'b0, t);
            ST_RSP_STATUS:  simple_token(c, CH_SPACE, 1'b0, SET_WORD, KIND_STATUS,
                                         ST_RSP_REASON, 1'b0, t);
            ST_RSP_REASON:  simple_token(c, CH_NUL, 1'b1, SET_LINE, KIND_REASON,
                                         ST_RSP_KEY, 1'b0, t);
            ST_RSP_KEY:     key_byte(c, ST_RSP_VALUE, t);
            ST_RSP_VALUE:   simple_token(c, CH_NUL, 1'b1, SET_VALUE, KIND_VALUE,
                                         ST_RSP_KEY, 1'b1, t);
            ST_RSP_BODY: begin
               t.token_kind = KIND_BODY;
               if (body_left <= 64'd1) begin
                  t.token_end = 1'b1;
                  t.event_res = EV_BODY_DONE;
                  restart();
               end else begin
                  body_left = body_left - 64'd1;
               end
            end
            default: restart();
         endcase
         expected_tags.push_back(t);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         error_count++;
         $display("MISMATCH %0s: got %0h, expected %0h", what, got, want);
      endtask

      task check_tag(tagged_byte_type got);
         tagged_byte_type want;
         if (expected_tags.size() == 0) begin
            report("unexpected item, byte", {24'd0, got.out_byte}, 32'd0);
            return;
         end
         want = expected_tags.pop_front();
         if (got.out_byte !== want.out_byte)
            report("out_byte", {24'd0, got.out_byte}, {24'd0, want.out_byte});
         if (got.token_kind !== want.token_kind)
            report("token_kind", {28'd0, got.token_kind}, {28'd0, want.token_kind});
         if (got.is_delimiter !== want.is_delimiter)
            report("is_delimiter", {31'd0, got.is_delimiter}, {31'd0, want.is_delimiter});
         if (got.token_end !== want.token_end)
            report("token_end", {31'd0, got.token_end}, {31'd0, want.token_end});
         if (got.event_res !== want.event_res)
            report("event_res", {29'd0, got.event_res}, {29'd0, want.event_res});
         if (got.content_length !== want.content_length)
            report("content_length", got.content_length, want.content_length);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;
   logic idle_on = 1'b1;
   int   stall_left = 0;
   int   cycle_count = 0;
   int   phase_sent = 0;

   hhsp_req_if req_ch ();
   hhsp_rsp_if rsp_ch ();

   tag_scoreboard tags = new();

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      rsp_ch.ready = 1'b0;
   end

   http_header_stream_parser_core #(.LENGTH_BITS(32)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   always begin
      #CLOCK_HIGH clock = 1'b1;
      #CLOCK_LOW  clock = 1'b0;
   end

   // The run is cut off if it goes on far longer than a correct one could.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The receiver stalls in short random bursts while idling is enabled.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Outputs are sampled in the middle of the cycle, where they are settled;
   // an item seen with valid and ready here is taken at the next rising edge.
   always @(negedge clock) begin
      tagged_byte_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out_byte = rsp_ch.out_byte;
         got.token_kind = rsp_ch.token_kind;
         got.is_delimiter = rsp_ch.is_delimiter;
         got.token_end = rsp_ch.token_end;
         got.event_res = rsp_ch.event_res;
         got.content_length = rsp_ch.content_length;
         tags.check_tag(got);
      end
   end

   // Offers one byte, possibly after a short gap, and returns once it has
   // been taken. Valid stays high afterwards so that bytes can run back to
   // back; stop_sending lowers it.
   task send_byte(logic [7:0] b);
      logic taken;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      tags.note_byte(b);
      phase_sent++;
   endtask

   task stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task send_queue(ref logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i]);
      q.delete();
   endtask

   // Holds the sender back until every predicted item has come back, then
   // lets the result stage empty.
   task drain();
      stop_sending();
      while (tags.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_mode(logic m);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tags.set_mode(m);
   endtask

   function automatic void push_text(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   // Printable characters other than space and colon, so that a token ends
   // only where the message puts its marker.
   function automatic logic [7:0] word_char();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_COLON);
      return c;
   endfunction

   function automatic void push_word(ref logic [7:0] q[$], input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) q.push_back(word_char());
   endfunction

   // Header lines with random content, often including a length field whose
   // value comes in a well-formed or a broken shape.
   function automatic int push_headers(ref logic [7:0] q[$]);
      int body_len;
      int shape;
      body_len = 0;
      repeat ($urandom_range(0, 3)) begin
         shape = $urandom_range(0, 9);
         if (shape < 4) begin
            body_len = $urandom_range(0, 12);
            push_text(q, "Content-Length:");
            if ($urandom_range(0, 1)) push_text(q, " ");
            if ($urandom_range(0, 3) == 0) q.push_back(CH_TAB);
            if ($urandom_range(0, 3) == 0) push_text(q, "00");
            push_text(q, $sformatf("%0d", body_len));
            if ($urandom_range(0, 3) == 0) push_text(q, " ");
         end else if (shape == 4) begin
            push_text(q, "Content-Length: ");
            push_text(q, $urandom_range(0, 1) ? "1 2" : "9x");
         end else if (shape == 5) begin
            push_text(q, $urandom_range(0, 1) ? "Content-Lengt:" : "Content-Lengthh:");
            push_word(q, 0, 4);
         end else begin
            push_word(q, 0, 6);
            q.push_back(CH_COLON);
            repeat ($urandom_range(0, 8)) begin
               q.push_back($urandom_range(0, 5) == 0 ? CH_SPACE : word_char());
            end
         end
         push_text(q, "\r\n");
      end
      push_text(q, "\r\n");
      return body_len;
   endfunction

   // A random message of the current mode. Now and then a byte is replaced
   // by noise, which breaks the message somewhere along its way.
   task send_message(logic m);
      logic [7:0] q[$];
      int body_len;
      if (!m) begin
         push_word(q, 0, 5);
         q.push_back(CH_SPACE);
         push_word(q, 0, 6);
         push_text(q, " HTTP/1.1\r\n");
         void'(push_headers(q));
      end else begin
         push_text(q, "HTTP/1.1 ");
         push_text(q, $sformatf("%0d", $urandom_range(100, 599)));
         q.push_back(CH_SPACE);
         push_word(q, 0, 5);
         push_text(q, "\r\n");
         body_len = push_headers(q);
         repeat (body_len) q.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
         q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
      end
      send_queue(q);
   endtask

   task random_phase(logic m, logic hold_midway);
      logic held;
      held = 1'b0;
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
         send_message(m);
         if (hold_midway && !held && phase_sent > PHASE_BYTES / 2) begin
            drain();
            held = 1'b1;
         end
      end
   endtask

   initial begin
      logic [7:0] q[$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Request mode: a full request, extreme bytes in the method, a NUL,
      // a CR that is not followed by LF, and a key line without a colon.
      push_text(q, "GET / HTTP/1.1\r\nHost: a b\r\n\r\n");
      q.push_back(8'hFF);
      q.push_back(8'h80);
      q.push_back(CH_NUL);
      push_text(q, "  HTTP/1.1\rX");
      push_text(q, "A B C\r\nHost\r\n");
      send_queue(q);

      // Response mode: zero length, a one-byte body, bad lengths, an
      // ignored second field, and finally the largest length, left pending.
      write_mode(1'b1);
      push_text(q, "HTTP/1.1 200 OK\r\nContent-Length: 0\r\n\r\n");
      push_text(q, "V S R\r\nContent-Length:\t 1 \r\nContent-Length: 7\r\n\r\n");
      q.push_back(8'h00);
      push_text(q, "V S R\r\nContent-Length: 4294967296\r\n\r\n");
      push_text(q, "V S R\r\nContent-Length:\r\n\r\n");
      push_text(q, "V S R\r\ncontent-length: 5\r\n\r\n");
      push_text(q, "V S R\r\nContent-Length: 4294967295\r\n\r\n");
      q.push_back(8'h7F);
      send_queue(q);

      write_mode(1'b0);
      random_phase(1'b0, 1'b0);
      write_mode(1'b1);
      random_phase(1'b1, 1'b1);
      write_mode(1'b0);
      random_phase(1'b0, 1'b0);
      write_mode(1'b1);
      idle_on = 1'b0;
      random_phase(1'b1, 1'b0);

      drain();
      repeat (8) @(posedge clock);
      if (tags.error_count == 0 && tags.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
